/* design/assert_macros.svh */
// Assertion helpers shared by the tokenizer modules.
// Each check is clocked on clk and held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define AST_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define AST_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define AST_CHECK(lbl, prop, msg)
`define AST_NEVER(lbl, cond, msg)

`endif

`endif

/* design/swt_pkg.sv */
package swt_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_LIT    = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_PHRASE = 2'd2,
    KIND_LABEL  = 2'd3
  } kind_t;

  // One result token
  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } token_t;

  // One queue entry: every result one input byte causes
  typedef struct packed {
    logic   pair;   // two tokens, first then second
    token_t first;
    token_t second;
  } entry_t;

  // Byte codes the lexer reacts to
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_BSL  = 8'h5C;

endpackage

/* design/swt_front.sv */
`include "assert_macros.svh"

module swt_front
  import swt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       pairs_mode,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  typedef enum logic [4:0] {
    MODE_BETWEEN = 5'b00001,
    MODE_BARE    = 5'b00010,
    MODE_SQUOTE  = 5'b00100,
    MODE_DQUOTE  = 5'b01000,
    MODE_COMMENT = 5'b10000
  } mode_t;

  mode_t mode, mode_next;
  logic  esc, esc_next;
  logic  label_used, label_used_next;
  logic  pairs_en;

  logic [7:0] c;
  logic [1:0] n_tok;
  token_t     tok0, tok1;
  logic       accept;
  logic       blank, brk;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  assign c     = end_of_input ? CH_NL : char_code;
  assign blank = (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_SP);
  assign brk   = (c == CH_NL) || (c == CH_SEMI);

  always_comb begin
    mode_next       = mode;
    esc_next        = esc;
    label_used_next = label_used;
    n_tok           = 2'd0;
    tok0            = '{kind: KIND_LIT, value: 8'h00};
    tok1            = '{kind: KIND_LIT, value: 8'h00};

    if (c != CH_CR) begin
      case (mode)
        MODE_BARE: begin
          if (esc) begin
            esc_next = 1'b0;
            if (c != CH_NL) begin
              n_tok = 2'd1;
              tok0  = '{kind: KIND_LIT, value: c};
            end
          end else if (brk || blank) begin
            mode_next       = MODE_BETWEEN;
            label_used_next = 1'b0;
            n_tok           = brk ? 2'd2 : 2'd1;
            tok0            = '{kind: KIND_WORD, value: 8'h00};
            tok1            = '{kind: KIND_PHRASE, value: 8'h00};
          end else if (c == CH_DQ) begin
            mode_next = MODE_DQUOTE;
          end else if (c == CH_SQ) begin
            mode_next = MODE_SQUOTE;
          end else if (c == CH_BSL) begin
            esc_next = 1'b1;
          end else if (c == CH_EQ && pairs_en && !label_used) begin
            mode_next       = MODE_BETWEEN;
            label_used_next = 1'b1;
            n_tok           = 2'd1;
            tok0            = '{kind: KIND_LABEL, value: 8'h00};
          end else begin
            n_tok = 2'd1;
            tok0  = '{kind: KIND_LIT, value: c};
          end
        end
        MODE_SQUOTE: begin
          if (c == CH_SQ) begin
            mode_next = MODE_BARE;
          end else begin
            n_tok = 2'd1;
            tok0  = '{kind: KIND_LIT, value: c};
          end
        end
        MODE_DQUOTE: begin
          if (esc) begin
            esc_next = 1'b0;
            if (c == CH_DQ || c == CH_BSL) begin
              n_tok = 2'd1;
              tok0  = '{kind: KIND_LIT, value: c};
            end else if (c != CH_NL) begin
              // unknown escape inside double quotes: keep the backslash
              n_tok = 2'd2;
              tok0  = '{kind: KIND_LIT, value: CH_BSL};
              tok1  = '{kind: KIND_LIT, value: c};
            end
          end else if (c == CH_DQ) begin
            mode_next = MODE_BARE;
          end else if (c == CH_BSL) begin
            esc_next = 1'b1;
          end else begin
            n_tok = 2'd1;
            tok0  = '{kind: KIND_LIT, value: c};
          end
        end
        MODE_COMMENT: begin
          if (c == CH_NL) begin
            mode_next = MODE_BETWEEN;
            n_tok     = 2'd1;
            tok0      = '{kind: KIND_PHRASE, value: 8'h00};
          end
        end
        default: begin
          // between words
          mode_next = MODE_BETWEEN;
          if (esc) begin
            esc_next = 1'b0;
            if (c != CH_NL) begin
              mode_next = MODE_BARE;
              n_tok     = 2'd1;
              tok0      = '{kind: KIND_LIT, value: c};
            end
          end else if (brk) begin
            n_tok = 2'd1;
            tok0  = '{kind: KIND_PHRASE, value: 8'h00};
          end else if (blank) begin
            mode_next = MODE_BETWEEN;
          end else if (c == CH_DQ) begin
            mode_next = MODE_DQUOTE;
          end else if (c == CH_HASH) begin
            mode_next = MODE_COMMENT;
          end else if (c == CH_SQ) begin
            mode_next = MODE_SQUOTE;
          end else if (c == CH_BSL) begin
            esc_next = 1'b1;
          end else begin
            mode_next = MODE_BARE;
            n_tok     = 2'd1;
            tok0      = '{kind: KIND_LIT, value: c};
          end
        end
      endcase
    end
  end

  assign push              = accept && (n_tok != 2'd0);
  assign push_entry.pair   = (n_tok == 2'd2);
  assign push_entry.first  = tok0;
  assign push_entry.second = tok1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_BETWEEN;
      esc        <= 1'b0;
      label_used <= 1'b0;
      pairs_en   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pairs_en <= pairs_mode;
      end
      if (accept) begin
        mode       <= mode_next;
        esc        <= esc_next;
        label_used <= label_used_next;
      end
    end
  end

  // an escape is only ever pending in a mode that honors it
  `AST_NEVER(front_esc_mode, esc && (mode == MODE_SQUOTE || mode == MODE_COMMENT), "stray escape")

endmodule

/* design/swt_queue.sv */
`include "assert_macros.svh"

module swt_queue
  import swt_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  output logic   head_valid,
  output entry_t head,
  input  logic   pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `AST_NEVER(queue_overflow, push && full, "push into full queue")
  `AST_NEVER(queue_underflow, pop && !head_valid, "pop from empty queue")

endmodule

/* design/swt_back.sv */
`include "assert_macros.svh"

module swt_back
  import swt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  entry_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] token_kind,
  output logic [7:0] char_value,
  output logic       last_of_run
);

  logic   vld;
  token_t tok;
  logic   last;
  logic   pend;      // second token of a pair still to go
  token_t pend_tok;
  logic   slot_free;

  assign slot_free = !vld || !out_stall;
  assign pop       = slot_free && !pend && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= 1'b0;
      pend <= 1'b0;
    end else if (slot_free) begin
      if (pend) begin
        vld  <= 1'b1;
        pend <= 1'b0;
      end else begin
        vld  <= head_valid;
        pend <= head_valid && head.pair;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend) begin
        tok  <= pend_tok;
        last <= 1'b1;
      end else if (head_valid) begin
        tok      <= head.first;
        last     <= !head.pair;
        pend_tok <= head.second;
      end
    end
  end

  assign out_valid   = vld;
  assign token_kind  = tok.kind;
  assign char_value  = tok.value;
  assign last_of_run = last;

  // a held second token always sits behind a shown first token of the pair
  `AST_CHECK(back_pend_shown, pend |-> (vld && !last), "pending token without its first")
  `AST_CHECK(back_first_pend, (vld && !last) |-> pend, "non-final token with nothing pending")

endmodule

/* design/shell_word_tokenizer_top.sv */
// Channel  Direction  Handshake              Payload
// -------  ---------  ---------------------  ---------------------------------------
// in       input      in_valid / in_stall    char_code[7:0], end_of_input
// out      output     out_valid / out_stall  token_kind[1:0], char_value[7:0], last_of_run
// cfg      input      cfg_valid / cfg_ready  pairs_mode
//
// Cycles: one input byte per clock while in_stall is low; a byte is classified in
// the cycle it is taken and its results enter the token queue at that edge; the
// emitter then loads them from the queue into its single output register, and
// bytes with two results show their two tokens there in turn.
// Reset: rst is synchronous, active high; it returns the lexer to between words,
// clears the escape and label flags, clears pairs_mode and empties the queue.
// Stalls: in_stall rises only when the token queue is full; out_stall holds the
// output register and backs the queue up without touching the lexer state.

module shell_word_tokenizer_top
  import swt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  // byte input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  // configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       pairs_mode,
  // token output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] token_kind,
  output logic [7:0] char_value,
  output logic       last_of_run
);

  // front to queue
  logic   push;
  entry_t push_entry;
  logic   q_full;

  // queue to back
  logic   head_valid;
  entry_t head;
  logic   pop;

  // Front end: hold the lexer state, classify each byte, and push every
  // result it causes as one queue entry. Bytes with no result push nothing.
  swt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .pairs_mode   (pairs_mode),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  // Token queue: decouple the lexer from the output so that either side can
  // stall alone; its QUEUE_DEPTH entries absorb the second token of two-token bytes.
  swt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Back end: drain entries into the output register, one token per
  // transfer, and mark the last token of each byte.
  swt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_kind  (token_kind),
    .char_value  (char_value),
    .last_of_run (last_of_run)
  );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import swt_pkg::*;

  // Lexer modes as the predictor tracks them
  typedef enum logic [2:0] {
    LX_GAP     = 3'd0,
    LX_BARE    = 3'd1,
    LX_SQUOTE  = 3'd2,
    LX_DQUOTE  = 3'd3,
    LX_COMMENT = 3'd4
  } lex_mode_t;

  // One expected token plus its end-of-run flag
  typedef struct {
    token_t tok;
    logic   last;
  } token_exp_t;

  // Word-splitting predictor and token scoreboard. Every accepted byte is run
  // through a private copy of the lexer state; the tokens it yields are queued
  // and each accepted output transfer is checked against the oldest one.
  class token_scoreboard;
    lex_mode_t  mode;
    bit         esc;
    bit         label_done;
    bit         pairs;
    token_t     run[$];
    token_exp_t want[$];
    int         errors;

    function new();
      mode       = LX_GAP;
      esc        = 1'b0;
      label_done = 1'b0;
      pairs      = 1'b0;
      errors     = 0;
    endfunction

    function void set_pairs(logic v);
      pairs = v;
    endfunction

    function int pending();
      return want.size();
    endfunction

    // Queue a token for this byte; a byte never yields more than two.
    function void put(kind_t k, logic [7:0] v);
      token_t t;
      t.kind  = k;
      t.value = (k == KIND_LIT) ? v : 8'h00;
      if (run.size() < 2) run.push_back(t);
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR || c == CH_SP;
    endfunction

    function void lex_gap(logic [7:0] c);
      mode = LX_GAP;
      if (esc) begin
        // escaped byte starts a word; escaped newline is a continuation
        esc = 1'b0;
        if (c != CH_NL) begin
          put(KIND_LIT, c);
          mode = LX_BARE;
        end
        return;
      end
      if (c == CH_NL || c == CH_SEMI) put(KIND_PHRASE, 8'h00);
      else if (is_blank(c)) ;
      else if (c == CH_DQ) mode = LX_DQUOTE;
      else if (c == CH_HASH) mode = LX_COMMENT;
      else if (c == CH_SQ) mode = LX_SQUOTE;
      else if (c == CH_BSL) esc = 1'b1;
      else begin
        // a leading '=' lands here too: literal, never a label
        put(KIND_LIT, c);
        mode = LX_BARE;
      end
    endfunction

    function void lex_bare(logic [7:0] c);
      if (esc) begin
        esc = 1'b0;
        if (c != CH_NL) put(KIND_LIT, c);
        return;
      end
      if (c == CH_NL || c == CH_SEMI || is_blank(c)) begin
        // close the word, then let newline or ';' close the phrase
        put(KIND_WORD, 8'h00);
        mode       = LX_GAP;
        label_done = 1'b0;
        if (c == CH_NL || c == CH_SEMI) lex_gap(c);
      end else if (c == CH_DQ) begin
        mode = LX_DQUOTE;
      end else if (c == CH_SQ) begin
        mode = LX_SQUOTE;
      end else if (c == CH_BSL) begin
        esc = 1'b1;
      end else if (c == CH_EQ && pairs && !label_done) begin
        put(KIND_LABEL, 8'h00);
        mode       = LX_GAP;
        label_done = 1'b1;
      end else begin
        put(KIND_LIT, c);
      end
    endfunction

    function void lex_dquote(logic [7:0] c);
      if (esc) begin
        // only quote, backslash and newline are escapable in double quotes
        esc = 1'b0;
        if (c == CH_NL) ;
        else if (c == CH_DQ || c == CH_BSL) put(KIND_LIT, c);
        else begin
          put(KIND_LIT, CH_BSL);
          put(KIND_LIT, c);
        end
        return;
      end
      if (c == CH_DQ) mode = LX_BARE;
      else if (c == CH_BSL) esc = 1'b1;
      else put(KIND_LIT, c);
    endfunction

    function void note_byte(logic [7:0] code, logic eoi);
      token_exp_t e;
      logic [7:0] c;
      run.delete();
      c = eoi ? CH_NL : code;
      // carriage return vanishes in every mode
      if (c == CH_CR) return;
      case (mode)
        LX_BARE:   lex_bare(c);
        LX_SQUOTE: begin
          if (c == CH_SQ) mode = LX_BARE;
          else put(KIND_LIT, c);
        end
        LX_DQUOTE: lex_dquote(c);
        LX_COMMENT: begin
          if (c == CH_NL) lex_gap(c);
        end
        default:   lex_gap(c);
      endcase
      foreach (run[i]) begin
        e.tok  = run[i];
        e.last = (i == run.size() - 1);
        want.push_back(e);
      end
    endfunction

    function void check_token(logic [1:0] kind, logic [7:0] value, logic last);
      token_exp_t e;
      if (want.size() == 0) begin
        $error("token with none expected: token_kind %0d char_value %0d", kind, value);
        errors++;
        return;
      end
      e = want.pop_front();
      if (kind !== e.tok.kind) begin
        $error("token_kind: expected %0d, actual %0d", e.tok.kind, kind);
        errors++;
      end
      if (value !== e.tok.value) begin
        $error("char_value: expected %0d, actual %0d", e.tok.value, value);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_of_run: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  // Cycles with no transfer on any channel before the run is called hung
  localparam int QUIET_LIMIT = 2000;
  // Length of the long receiver hold-off
  localparam int HOLD_CYCLES = 300;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] char_code;
  logic       end_of_input;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       pairs_mode;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] token_kind;
  logic [7:0] char_value;
  logic       last_of_run;

  token_scoreboard sb = new();

  int tx_idle;    // percent of transfers followed by a sender gap
  int rx_idle;    // percent of cycles the receiver stalls
  bit hold_req;   // ask the stall process for one long hold-off
  int quiet;

  shell_word_tokenizer_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .pairs_mode   (pairs_mode),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .char_value   (char_value),
    .last_of_run  (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at the current rate; on request hold the output off for
  // a long stretch so the token queue fills and the input backs up.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle);
      end
    end
  end

  // Sample every channel on the edge; feed accepted bytes to the predictor,
  // check accepted tokens, and watch for a hung run.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_pairs(pairs_mode);
      if (in_valid && !in_stall) sb.note_byte(char_code, end_of_input);
      if (out_valid && !out_stall) sb.check_token(token_kind, char_value, last_of_run);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offer one byte and hold it until taken; then maybe leave a short gap.
  task automatic offer(input logic [7:0] c, input logic eoi);
    in_valid     <= 1'b1;
    char_code    <= c;
    end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic offer_text(input string s);
    foreach (s[i]) offer(s[i], 1'b0);
  endtask

  // Drop valid and wait until the block has drained every expected token.
  // The first edge lets the sampler note the last byte taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write pairs_mode while the block is idle.
  task automatic write_pairs(input logic v);
    drain();
    cfg_valid  <= 1'b1;
    pairs_mode <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Bias toward letters and the bytes the lexer reacts to, with some noise.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 32) return 8'($urandom_range(25) + 97);
    if (r < 40) return CH_EQ;
    if (r < 45) return CH_SP;
    if (r < 48) begin
      case ($urandom_range(2))
        0:       return CH_TAB;
        1:       return CH_VT;
        default: return CH_FF;
      endcase
    end
    if (r < 54) return CH_DQ;
    if (r < 59) return CH_SQ;
    if (r < 66) return CH_BSL;
    if (r < 71) return CH_NL;
    if (r < 75) return CH_SEMI;
    if (r < 78) return CH_HASH;
    if (r < 81) return CH_CR;
    return 8'($urandom_range(255));
  endfunction

  task automatic random_phase(input int count, input int tx, input int rx, input bit squeeze);
    tx_idle = tx;
    rx_idle = rx;
    for (int i = 0; i < count; i++) begin
      // hold the receiver off while bytes keep coming, then pause the sender
      // until every pending token has come out
      if (squeeze && i == count / 3) hold_req = 1'b1;
      if (squeeze && i == count / 3 + 60) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      if ($urandom_range(99) < 5)
        offer(8'($urandom_range(255)), 1'b1);
      else
        offer(pick_byte(), 1'b0);
    end
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    char_code    = 8'h00;
    end_of_input = 1'b0;
    cfg_valid    = 1'b0;
    pairs_mode   = 1'b0;
    tx_idle      = 0;
    rx_idle      = 0;
    hold_req     = 1'b0;
    quiet        = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // '=' stays literal with labels off; ';' closes word and phrase
    offer_text("a=b;");
    write_pairs(1'b1);
    // leading '=' literal, then label end; tab ends a word; continuation
    offer_text("=k=v\tw\\\n");
    // double quotes: other escape gives two tokens, escaped quote, CR dropped
    offer_text("\"\\z\\\"\015'#");
    // end of input inside the quote is a literal newline
    offer(8'hA5, 1'b1);
    offer_text("\";");
    // extreme bytes, vertical tab and form feed as blanks, comment to the end
    offer(8'hFF, 1'b0);
    offer(CH_VT, 1'b0);
    offer(8'h00, 1'b0);
    offer(CH_FF, 1'b0);
    offer_text("#x");
    offer(8'h5A, 1'b1);
    // single quotes keep a backslash literal
    offer_text("'\\'");

    random_phase(600, 10, 48, 1'b1);
    write_pairs(1'b0);
    random_phase(600, 48, 10, 1'b0);
    write_pairs(1'b1);
    random_phase(600, 0, 0, 1'b0);
    drain();

    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/swt_pkg.sv
design/swt_front.sv
design/swt_queue.sv
design/swt_back.sv
design/shell_word_tokenizer_top.sv
sim/tb.sv
